// ===== sv/fcca_pkg.sv =====
`timescale 1ns / 1ps

package fcca_pkg;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_RESIZE = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_NOFILE  = 3'd2,
        ST_NOSPACE = 3'd3,
        ST_BUSY    = 3'd4,
        ST_BADLEN  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_LOOKUP,
        S_CR_RD,
        S_CR_EV,
        S_TAIL,
        S_WK_RD,
        S_WK_EV,
        S_EX_RD,
        S_EX_EV,
        S_FR_RD,
        S_FR_EV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] file_slot;
        logic [6:0] length;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] first_cluster;
        logic [6:0] free_count;
    } rsp_t;

endpackage

// ===== sv/fat_cluster_chain_allocator.sv =====
`timescale 1ns / 1ps

// fat-style cluster chain allocator. a command item is taken when start is high and busy
// is low; exactly one result item follows, shown for one cycle with done high, and the
// receiver cannot stall it. steps per item: a refused command or a query goes through
// lookup, result and idle; each visited cluster adds a cluster table read, then an
// evaluate/write step. a create scans clusters and then writes the chain tail, a delete
// frees clusters, a resize that keeps or cuts the chain walks and then frees clusters,
// and a resize that grows it walks, scans and then writes the chain tail. the result
// shows in the cycle just before the idle one. after reset and after every write of
// the volume size register all NUM_CLUSTERS entries of the cluster table are cleared,
// one entry per cycle, while busy is high; the register write also empties every slot.
// in idle the register is not taken in a cycle where start is high.
module fat_cluster_chain_allocator
    import fcca_pkg::*;
#(
    parameter int NUM_CLUSTERS = 64,
    parameter int DIR_SLOTS    = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    // command items
    input  logic       start,
    output logic       busy,
    input  req_t       req,
    // result items
    output logic       done,
    output rsp_t       rsp,
    // volume size register
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_data
);

    // widths
    localparam int CW   = $clog2(NUM_CLUSTERS);          // cluster index
    localparam int CNTW = $clog2(NUM_CLUSTERS + 1);      // cluster count
    localparam int LW   = (CNTW > 7) ? CNTW : 7;          // length counter
    localparam int SW   = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
    localparam int EW   = CW + 2;                         // table entry: used, end, link
    localparam int RESET_VOL = (NUM_CLUSTERS < 64) ? NUM_CLUSTERS : 64;

    // effective volume size: clamp to 1..NUM_CLUSTERS
    function automatic logic [CNTW-1:0] eff_size(input logic [6:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0) w = 32'd1;
        if (w > 32'(NUM_CLUSTERS)) w = 32'(NUM_CLUSTERS);
        return CNTW'(w);
    endfunction

    function automatic logic [EW-1:0] entry(input logic used, input logic last,
                                            input logic [CW-1:0] link);
        return {used, last, link};
    endfunction

    state_t               state_reg, state_next;
    logic [CNTW-1:0]      vol_reg, vol_next;
    logic [CNTW-1:0]      free_reg, free_next;
    logic [DIR_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [SW-1:0]        slot_reg, slot_next;
    logic                 slot_ok_reg, slot_ok_next;
    logic [6:0]           len_reg, len_next;
    logic [CW-1:0]        cur_reg, cur_next;
    logic [CW-1:0]        prev_reg, prev_next;
    logic [CW-1:0]        start_reg, start_next;
    logic [LW-1:0]        cnt_reg, cnt_next;
    status_t              status_reg, status_next;

    // cluster table: used flag, end-of-chain flag, link
    logic [EW-1:0] cl_mem [NUM_CLUSTERS];
    logic [EW-1:0] cl_rdata;
    logic          cl_we;
    logic [CW-1:0] cl_waddr;
    logic [EW-1:0] cl_wdata;

    // directory start clusters
    logic [CW-1:0] slot_mem [DIR_SLOTS];
    logic [CW-1:0] slot_rdata;
    logic          slot_we;

    logic accept, cfg_fire;
    logic r_free, r_end;
    logic [CW-1:0] r_link;
    logic slot_vld, len_zero, cr_noroom, cr_last, wk_fit, ex_noroom, ex_last, clr_last;
    logic [LW-1:0] need;
    logic [CW-1:0] scan_nxt;

    always_ff @(posedge clk)
    begin
        if (cl_we)
        begin
            cl_mem[cl_waddr] <= cl_wdata;
        end
        cl_rdata <= cl_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_reg] <= cur_reg;
        end
        slot_rdata <= slot_mem[SW'(req.file_slot)];
    end

    // shared decisions
    always_comb
    begin
        accept    = start && (state_reg == S_IDLE);
        cfg_fire  = cfg_valid && cfg_ready;
        r_free    = !cl_rdata[CW+1];
        r_end     = cl_rdata[CW];
        r_link    = cl_rdata[CW-1:0];
        slot_vld  = slot_valid_reg[slot_reg];
        len_zero  = (len_reg == 7'd0);
        cr_noroom = 32'(len_reg) > 32'(free_reg);
        cr_last   = r_free && ((cnt_reg + LW'(1)) == LW'(len_reg));
        wk_fit    = cnt_reg >= LW'(len_reg);
        need      = LW'(len_reg) - cnt_reg;
        ex_noroom = 32'(need) > 32'(free_reg);
        ex_last   = r_free && (cnt_reg == LW'(1));
        clr_last  = (cur_reg == CW'(NUM_CLUSTERS - 1));
        // upward scan wraps after the last volume cluster
        if (32'(cur_reg) + 32'd1 >= 32'(vol_reg))
        begin
            scan_nxt = '0;
        end
        else
        begin
            scan_nxt = cur_reg + CW'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    state_next = S_CLEAR;
                end
                else if (accept)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_CLEAR:
            begin
                if (clr_last && !cfg_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_DONE;
                if (slot_ok_reg)
                begin
                    case (cmd_reg)
                        CMD_CREATE:
                        begin
                            if (!(len_zero || slot_vld || cr_noroom))
                            begin
                                state_next = S_CR_RD;
                            end
                        end
                        CMD_RESIZE:
                        begin
                            if (slot_vld && !len_zero)
                            begin
                                state_next = S_WK_RD;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (slot_vld)
                            begin
                                state_next = S_FR_RD;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_CR_RD: state_next = S_CR_EV;
            S_CR_EV: state_next = cr_last ? S_TAIL : S_CR_RD;
            S_TAIL:  state_next = S_DONE;
            S_WK_RD: state_next = S_WK_EV;
            S_WK_EV:
            begin
                if (wk_fit)
                begin
                    state_next = r_end ? S_DONE : S_FR_RD;
                end
                else if (r_end)
                begin
                    state_next = ex_noroom ? S_DONE : S_EX_RD;
                end
                else
                begin
                    state_next = S_WK_RD;
                end
            end
            S_EX_RD: state_next = S_EX_EV;
            S_EX_EV: state_next = ex_last ? S_TAIL : S_EX_RD;
            S_FR_RD: state_next = S_FR_EV;
            S_FR_EV: state_next = r_end ? S_DONE : S_FR_RD;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and table writes
    always_comb
    begin
        vol_next        = vol_reg;
        free_next       = free_reg;
        slot_valid_next = slot_valid_reg;
        cmd_next        = cmd_reg;
        slot_next       = slot_reg;
        slot_ok_next    = slot_ok_reg;
        len_next        = len_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        start_next      = start_reg;
        cnt_next        = cnt_reg;
        status_next     = status_reg;
        cl_we           = 1'b0;
        cl_waddr        = cur_reg;
        cl_wdata        = entry(1'b0, 1'b1, '0);
        slot_we         = 1'b0;

        // a register write reformats the volume
        if (cfg_fire)
        begin
            vol_next        = eff_size(cfg_data);
            free_next       = eff_size(cfg_data);
            slot_valid_next = '0;
            cur_next        = '0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = req.cmd;
                    slot_next    = SW'(req.file_slot);
                    slot_ok_next = 32'(req.file_slot) < 32'(DIR_SLOTS);
                    len_next     = req.length;
                end
            end
            S_CLEAR:
            begin
                cl_we    = 1'b1;
                cl_waddr = cur_reg;
                cl_wdata = entry(1'b0, 1'b1, '0);
                if (!cfg_fire)
                begin
                    cur_next = clr_last ? '0 : cur_reg + CW'(1);
                end
            end
            S_LOOKUP:
            begin
                status_next = ST_OK;
                start_next  = slot_rdata;
                if (!slot_ok_reg)
                begin
                    status_next = ST_NOFILE;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_CREATE:
                        begin
                            if (len_zero)
                            begin
                                status_next = ST_BADLEN;
                            end
                            else if (slot_vld)
                            begin
                                status_next = ST_BUSY;
                            end
                            else if (cr_noroom)
                            begin
                                status_next = ST_FULL;
                            end
                            cur_next = '0;
                            cnt_next = '0;
                        end
                        CMD_RESIZE:
                        begin
                            if (!slot_vld)
                            begin
                                status_next = ST_NOFILE;
                            end
                            else if (len_zero)
                            begin
                                status_next = ST_BADLEN;
                            end
                            cur_next = slot_rdata;
                            cnt_next = LW'(1);
                        end
                        CMD_DELETE:
                        begin
                            if (!slot_vld)
                            begin
                                status_next = ST_NOFILE;
                            end
                            else
                            begin
                                slot_valid_next[slot_reg] = 1'b0;
                            end
                            cur_next = slot_rdata;
                        end
                        default: status_next = ST_OK;
                    endcase
                end
            end
            S_CR_EV:
            begin
                // first-fit: link each free cluster behind the previous one
                if (r_free)
                begin
                    if (cnt_reg == '0)
                    begin
                        slot_we    = 1'b1;
                        start_next = cur_reg;
                    end
                    else
                    begin
                        cl_we    = 1'b1;
                        cl_waddr = prev_reg;
                        cl_wdata = entry(1'b1, 1'b0, cur_reg);
                    end
                    prev_next = cur_reg;
                    cnt_next  = cnt_reg + LW'(1);
                    free_next = free_reg - CNTW'(1);
                end
                if (!cr_last)
                begin
                    cur_next = cur_reg + CW'(1);
                end
            end
            S_TAIL:
            begin
                cl_we    = 1'b1;
                cl_waddr = prev_reg;
                cl_wdata = entry(1'b1, 1'b1, '0);
                slot_valid_next[slot_reg] = 1'b1;
            end
            S_WK_EV:
            begin
                if (wk_fit)
                begin
                    // cut here, then free the tail
                    if (!r_end)
                    begin
                        cl_we    = 1'b1;
                        cl_waddr = cur_reg;
                        cl_wdata = entry(1'b1, 1'b1, '0);
                        cur_next = r_link;
                    end
                end
                else if (r_end)
                begin
                    if (ex_noroom)
                    begin
                        status_next = ST_NOSPACE;
                    end
                    else
                    begin
                        cnt_next  = need;
                        prev_next = cur_reg;
                        cur_next  = scan_nxt;
                    end
                end
                else
                begin
                    cur_next = r_link;
                    cnt_next = cnt_reg + LW'(1);
                end
            end
            S_EX_EV:
            begin
                if (r_free)
                begin
                    cl_we     = 1'b1;
                    cl_waddr  = prev_reg;
                    cl_wdata  = entry(1'b1, 1'b0, cur_reg);
                    prev_next = cur_reg;
                    free_next = free_reg - CNTW'(1);
                    cnt_next  = cnt_reg - LW'(1);
                end
                cur_next = scan_nxt;
            end
            S_FR_EV:
            begin
                cl_we     = 1'b1;
                cl_waddr  = cur_reg;
                cl_wdata  = entry(1'b0, 1'b1, '0);
                free_next = free_reg + CNTW'(1);
                cur_next  = r_link;
            end
            default:
            begin
                cl_we = 1'b0;
            end
        endcase
    end

    // handshake and result; a command item wins over a register write in idle
    always_comb
    begin
        busy      = (state_reg != S_IDLE);
        cfg_ready = ((state_reg == S_IDLE) && !start) || (state_reg == S_CLEAR);
        done      = (state_reg == S_DONE);
        rsp.status = status_reg;
        rsp.first_cluster = (slot_ok_reg && slot_valid_reg[slot_reg]) ? 6'(start_reg) : 6'd0;
        rsp.free_count    = 7'(free_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            vol_reg        <= CNTW'(RESET_VOL);
            free_reg       <= CNTW'(RESET_VOL);
            slot_valid_reg <= '0;
            cur_reg        <= '0;
            slot_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            vol_reg        <= vol_next;
            free_reg       <= free_next;
            slot_valid_reg <= slot_valid_next;
            cur_reg        <= cur_next;
            slot_ok_reg    <= slot_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        slot_reg   <= slot_next;
        len_reg    <= len_next;
        prev_reg   <= prev_next;
        start_reg  <= start_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import fcca_pkg::*;

    localparam int NCL = 64;
    localparam int NSLOT = 16;
    localparam int LINK_NONE = -1;
    localparam int STALL_LIMIT = 5000;

    // cluster table and directory as the block should hold them, plus the results
    // still owed; commands are noted when accepted, results checked when strobed
    class chain_table_model;
        int      link_of[NCL];
        bit      in_use[NCL];
        bit      slot_live[NSLOT];
        int      slot_head[NSLOT];
        int      free_cnt;
        int      vol;
        rsp_t    owed[$];
        int      errors;

        function void reformat(logic [6:0] v);
            vol = (v < 1) ? 1 : ((v > NCL) ? NCL : int'(v));
            for (int i = 0; i < NCL; i++)
            begin
                in_use[i] = 0;
                link_of[i] = LINK_NONE;
            end
            for (int i = 0; i < NSLOT; i++)
            begin
                slot_live[i] = 0;
                slot_head[i] = 0;
            end
            free_cnt = vol;
        endfunction

        function int release_chain(int c);
            int n;
            int nx;
            n = 0;
            while (c >= 0 && c < NCL && n < NCL)
            begin
                nx = link_of[c];
                in_use[c] = 0;
                link_of[c] = LINK_NONE;
                n++;
                c = nx;
            end
            return n;
        endfunction

        function status_t do_create(int s, int len);
            int got;
            int prev;
            got = 0;
            prev = LINK_NONE;
            if (len == 0) return ST_BADLEN;
            if (slot_live[s]) return ST_BUSY;
            if (len > free_cnt) return ST_FULL;
            for (int c = 0; c < vol && got < len; c++)
            begin
                if (!in_use[c])
                begin
                    in_use[c] = 1;
                    link_of[c] = LINK_NONE;
                    if (prev == LINK_NONE) slot_head[s] = c;
                    else link_of[prev] = c;
                    prev = c;
                    got++;
                end
            end
            slot_live[s] = 1;
            free_cnt -= got;
            return ST_OK;
        endfunction

        function status_t do_resize(int s, int len);
            int c;
            int n;
            int need;
            int p;
            int found;
            if (!slot_live[s]) return ST_NOFILE;
            if (len == 0) return ST_BADLEN;
            c = slot_head[s];
            n = 1;
            while (n < len && n < NCL && link_of[c] != LINK_NONE)
            begin
                c = link_of[c];
                n++;
            end
            // cut: drop everything past the new tail
            if (n >= len)
            begin
                if (link_of[c] != LINK_NONE)
                begin
                    p = link_of[c];
                    link_of[c] = LINK_NONE;
                    free_cnt += release_chain(p);
                end
                return ST_OK;
            end
            need = len - n;
            if (need > free_cnt) return ST_NOSPACE;
            // grow: scan upward from the tail, wrapping at the volume end
            while (need > 0)
            begin
                p = c;
                found = LINK_NONE;
                for (int k = 0; k < vol; k++)
                begin
                    p++;
                    if (p >= vol) p = 0;
                    if (!in_use[p])
                    begin
                        found = p;
                        break;
                    end
                end
                if (found == LINK_NONE) break;
                in_use[found] = 1;
                link_of[found] = LINK_NONE;
                link_of[c] = found;
                c = found;
                free_cnt--;
                need--;
            end
            return ST_OK;
        endfunction

        function void note_cmd(req_t r);
            rsp_t    e;
            status_t st;
            int      s;
            s = r.file_slot;
            case (r.cmd)
                CMD_CREATE: st = do_create(s, r.length);
                CMD_RESIZE: st = do_resize(s, r.length);
                CMD_DELETE:
                begin
                    if (!slot_live[s]) st = ST_NOFILE;
                    else
                    begin
                        free_cnt += release_chain(slot_head[s]);
                        slot_live[s] = 0;
                        st = ST_OK;
                    end
                end
                default: st = ST_OK;
            endcase
            e.status = st;
            e.first_cluster = slot_live[s] ? slot_head[s][5:0] : 6'd0;
            e.free_count = free_cnt[6:0];
            owed.push_back(e);
        endfunction

        function void check_rsp(rsp_t got);
            rsp_t e;
            if (owed.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result item %h", got);
                return;
            end
            e = owed.pop_front();
            if (got.status !== e.status || got.first_cluster !== e.first_cluster ||
                got.free_count !== e.free_count)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: status %0d/%0d first %0d/%0d free %0d/%0d (exp/act)",
                             e.status, got.status, e.first_cluster, got.first_cluster,
                             e.free_count, got.free_count);
            end
        endfunction
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       start = 0;
    logic       busy;
    req_t       req = '0;
    logic       done;
    rsp_t       rsp;
    logic       cfg_valid = 0;
    logic       cfg_ready;
    logic [6:0] cfg_data = '0;

    chain_table_model tbl = new();
    int stall_cycles = 0;
    int max_gap = 14;

    fat_cluster_chain_allocator u_top (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // results are sampled mid-cycle, away from the edge that changes them
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (done) tbl.check_rsp(rsp);
            if (done || (start && !busy) || (cfg_valid && cfg_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // one command item; the call returns just after the accepting edge so that a
    // following item with no gap keeps start high without lowering it
    task automatic put_cmd(req_t r);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        req <= r;
        forever
        begin
            @(negedge clk);
            if (!busy) break;
            @(posedge clk);
        end
        @(posedge clk);
        tbl.note_cmd(r);
    endtask

    task automatic mk_cmd(cmd_t c, int s, int len);
        req_t r;
        r.cmd = c;
        r.file_slot = 4'(s);
        r.length = 7'(len);
        put_cmd(r);
    endtask

    task automatic drain();
        start <= 0;
        while (tbl.owed.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // reformat the volume while idle; busy stays high through the table clear
    task automatic set_volume(logic [6:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data <= v;
        forever
        begin
            @(negedge clk);
            if (cfg_ready) break;
            @(posedge clk);
        end
        @(posedge clk);
        cfg_valid <= 0;
        tbl.reformat(v);
    endtask

    task automatic random_phase(int n);
        req_t r;
        int   pick;
        for (int i = 0; i < n; i++)
        begin
            // now and then switch to back-to-back items
            if (i % 40 == 0) max_gap = ($urandom_range(0, 3) == 0) ? 0 : 14;
            pick = $urandom_range(0, 99);
            r.file_slot = (pick < 85) ? 4'($urandom_range(0, 5)) : 4'($urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            if (pick < 35) r.cmd = CMD_CREATE;
            else if (pick < 70) r.cmd = CMD_RESIZE;
            else if (pick < 92) r.cmd = CMD_DELETE;
            else r.cmd = CMD_QUERY;
            pick = $urandom_range(0, 99);
            if (pick < 80) r.length = 7'($urandom_range(1, (tbl.vol + 3) / 4));
            else if (pick < 85) r.length = 7'd0;
            else if (pick < 93) r.length = 7'($urandom_range(1, tbl.vol));
            else r.length = 7'($urandom_range(0, 127));
            put_cmd(r);
        end
    endtask

    initial
    begin
        logic [6:0] vols[8];
        vols = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd17, 7'd40, 7'd64};
        tbl.errors = 0;
        tbl.reformat(7'd64);
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: refusals in check order, cut, grow with wraparound, query
        mk_cmd(CMD_CREATE, 0, 0);
        mk_cmd(CMD_CREATE, 0, 64);
        mk_cmd(CMD_CREATE, 1, 1);
        mk_cmd(CMD_CREATE, 0, 3);
        mk_cmd(CMD_RESIZE, 0, 64);
        mk_cmd(CMD_RESIZE, 0, 0);
        mk_cmd(CMD_RESIZE, 0, 10);
        mk_cmd(CMD_RESIZE, 5, 4);
        mk_cmd(CMD_CREATE, 1, 5);
        mk_cmd(CMD_CREATE, 2, 127);
        mk_cmd(CMD_RESIZE, 1, 127);
        mk_cmd(CMD_DELETE, 0, 127);
        mk_cmd(CMD_RESIZE, 1, 60);
        mk_cmd(CMD_QUERY, 1, 0);
        mk_cmd(CMD_QUERY, 15, 127);
        mk_cmd(CMD_DELETE, 15, 0);
        mk_cmd(CMD_CREATE, 15, 4);
        mk_cmd(CMD_RESIZE, 1, 2);
        mk_cmd(CMD_DELETE, 1, 0);
        mk_cmd(CMD_DELETE, 15, 0);

        foreach (vols[i])
        begin
            set_volume(i == 7 ? 7'($urandom_range(1, 64)) : vols[i]);
            random_phase(i < 4 ? 60 : 180);
            if (i == 5)
            begin
                // hold the sender until every owed result is back
                drain();
                random_phase(100);
            end
        end

        drain();
        if (tbl.errors == 0 && tbl.owed.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/fcca_pkg.sv
sv/fat_cluster_chain_allocator.sv
dv/tb_top.sv
